@@ rtl/core/wvs_pkg.sv @@
// ----------------------------------------------------------------------------
// wvs_pkg
// Shared types and constants of the waypoint velocity setpoint block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wvs_pkg;

  localparam int CAP_BITS = 30;
  localparam int SQ_W     = 62;
  localparam int ROOT_W   = 31;
  localparam int PROD_W   = 42;
  localparam int Q_W      = 12;
  localparam int VEL_W    = 13;
  localparam int LEG_W    = 2;
  localparam int OUT_W    = 48;
  localparam int LEG_LSB  = 3 * VEL_W;
  localparam int ARR_BIT  = LEG_LSB + LEG_W;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 16;

  localparam logic signed [15:0] LEG3_HEIGHT = 16'sd1000;

  localparam logic [CFG_AW-1:0] REG_MAX_SPEED    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_XY_TOLERANCE = 3'd1;
  localparam logic [CFG_AW-1:0] REG_Z_TOLERANCE  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_HOME_X       = 3'd3;
  localparam logic [CFG_AW-1:0] REG_HOME_Y       = 3'd4;
  localparam logic [CFG_AW-1:0] REG_HOVER_HEIGHT = 3'd5;
  localparam logic [CFG_AW-1:0] REG_SIDE_OFFSET  = 3'd6;

  localparam logic [LEG_W-1:0] LEG_DONE    = 2'd0;
  localparam logic [LEG_W-1:0] LEG_TAKEOFF = 2'd1;
  localparam logic [LEG_W-1:0] LEG_SIDE    = 2'd2;
  localparam logic [LEG_W-1:0] LEG_FINAL   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SQ,
    S_LIM,
    S_ROOT,
    S_MUL,
    S_DIV,
    S_FIN
  } wvs_state_t;

endpackage

`default_nettype wire

@@ rtl/core/wvs_sqrt.sv @@
// ----------------------------------------------------------------------------
// wvs_sqrt
// Serial ceiling square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wvs_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [wvs_pkg::SQ_W-1:0]   radicand,
  output logic                            done,
  output logic [wvs_pkg::ROOT_W-1:0]      root
);
  import wvs_pkg::*;

  logic [SQ_W-1:0] x_r, x_nxt, r_r, r_nxt, bit_r;
  logic [4:0]      cnt_r;
  logic            busy_r, done_r;
  logic [SQ_W-1:0] trial;

  always_comb begin
    trial = r_r + bit_r;
    if (x_r >= trial) begin
      x_nxt = x_r - trial;
      r_nxt = (r_r >> 1) + bit_r;
    end else begin
      x_nxt = x_r;
      r_nxt = r_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= radicand;
      r_r   <= '0;
      bit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_r) begin
      x_r   <= x_nxt;
      r_r   <= r_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0] + ROOT_W'(x_r != '0);

endmodule

`default_nettype wire

@@ rtl/core/wvs_div.sv @@
// ----------------------------------------------------------------------------
// wvs_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wvs_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [wvs_pkg::PROD_W-1:0] num,
  input  wire logic [wvs_pkg::ROOT_W-1:0] den,
  output logic                            done,
  output logic [wvs_pkg::Q_W-1:0]         quot
);
  import wvs_pkg::*;

  logic [ROOT_W-1:0] rem_r, den_r;
  logic [Q_W-1:0]    nb_r, q_r;
  logic [3:0]        cnt_r;
  logic              busy_r, done_r;
  logic [ROOT_W:0]   t;
  logic              ge;

  assign t  = {rem_r, nb_r[Q_W-1]};
  assign ge = t >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= ROOT_W'(num[PROD_W-1:Q_W]);
      nb_r  <= num[Q_W-1:0];
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? ROOT_W'(t - {1'b0, den_r}) : ROOT_W'(t);
      nb_r  <= nb_r << 1;
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

@@ rtl/core/waypoint_velocity_setpoint.sv @@
// ----------------------------------------------------------------------------
// waypoint_velocity_setpoint
// Velocity command toward the current leg target, speed limited, with leg
// sequencing on arrival.
// ----------------------------------------------------------------------------
// channel | dir | handshake             | payload
// in_     | in  | in_tvalid/in_tready   | meas_x, meas_y, meas_z
// out_    | out | out_tvalid/out_tready | vel_x, vel_y, vel_z, leg_now, arrived
// cfg_    | in  | cfg_we                | cfg_addr, cfg_wdata
// One sample at a time: setup, bit-serial shift-add squaring of each error
// component, then a compare and the output load; when the limit applies, a
// square root and one division per component come before the load.
// Reset clears the leg to take-off, loads the register defaults and empties
// the output register. A stalled output holds; the next sample is taken while
// it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module waypoint_velocity_setpoint #(
  parameter  int LEG_COUNT = 2,
  parameter  int POS_BITS  = 16,
  localparam int IN_W      = ((3 * POS_BITS + 7) / 8) * 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [IN_W-1:0]            in_tdata,   // meas_x, meas_y, meas_z
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [wvs_pkg::OUT_W-1:0]       out_tdata,  // vel_x, vel_y, vel_z, leg_now, arrived
  input  wire logic                       cfg_we,
  input  wire logic [wvs_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [wvs_pkg::CFG_DW-1:0] cfg_wdata
);
  import wvs_pkg::*;

  localparam int DW = ((POS_BITS > 17) ? POS_BITS : 17) + 1;

  wvs_state_t state_r, state_nxt;

  logic [11:0]        max_speed_r, xy_tol_r, z_tol_r;
  logic signed [15:0] home_x_r, home_y_r, side_off_r;
  logic [14:0]        hover_r;
  logic [LEG_W-1:0]   leg_r, leg_nxt, leg_eff;

  logic signed [POS_BITS-1:0] meas [3];
  logic signed [16:0]         tgt_y;
  logic signed [15:0]         tgt_z;
  logic signed [DW-1:0]       d_in [3];
  logic signed [DW-1:0]       d_r [3];
  logic [DW-1:0]              a_w [3];
  logic [DW-1:0]              a_or;
  logic [5:0]                 kk;
  logic [CAP_BITS-1:0]        a_r [3];
  logic                       arr_w, arr_r;
  logic [23:0]                msq_r;

  logic [SQ_W-1:0]     acc_r, mcand_r;
  logic [CAP_BITS-1:0] mpl_r;
  logic [4:0]          cnt_r;
  logic [1:0]          comp_r, comp_inc;
  logic                lim_r;
  logic [ROOT_W-1:0]   root_r;
  logic [Q_W-1:0]      q_r [3];

  logic              sq_start, sq_done, div_start, div_done, out_load, over;
  logic [ROOT_W-1:0] sq_root;
  logic [Q_W-1:0]    div_q;
  logic [PROD_W-1:0] prod;
  logic [VEL_W-1:0]  vel [3];
  logic              out_tvalid_r;
  logic [OUT_W-1:0]  out_tdata_r;

  assign comp_inc = comp_r + 2'd1;
  assign over     = acc_r > SQ_W'(msq_r);

  // ---- targets and errors
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      meas[i] = in_tdata[i*POS_BITS +: POS_BITS];
    end
    leg_eff = (leg_r == LEG_DONE) ? LEG_W'(LEG_COUNT) : leg_r;
    tgt_y   = (leg_eff == LEG_SIDE) ? 17'(home_y_r) + 17'(side_off_r) : 17'(home_y_r);
    tgt_z   = (leg_eff == LEG_FINAL) ? LEG3_HEIGHT : $signed({1'b0, hover_r});
    d_in[0] = DW'(home_x_r) - DW'(meas[0]);
    d_in[1] = DW'(tgt_y) - DW'(meas[1]);
    d_in[2] = DW'(tgt_z) - DW'(meas[2]);
  end

  // ---- magnitudes, common scaling, arrival
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_w[i] = d_r[i][DW-1] ? DW'(-d_r[i]) : DW'(d_r[i]);
    end
    a_or = a_w[0] | a_w[1] | a_w[2];
    kk   = '0;
    for (int j = 0; j < DW; j++) begin
      if (j >= CAP_BITS && a_or[j]) kk = 6'(j - CAP_BITS + 1);
    end
    arr_w = (a_w[0] < DW'(xy_tol_r)) && (a_w[1] < DW'(xy_tol_r)) &&
            (a_w[2] < DW'(z_tol_r)) &&
            ((25'(a_w[0][11:0]) * 25'(a_w[0][11:0]) +
              25'(a_w[1][11:0]) * 25'(a_w[1][11:0]))
             < 25'(xy_tol_r) * 25'(xy_tol_r));
  end

  // ---- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_PREP;
      S_PREP: state_nxt = S_SQ;
      S_SQ:   if (cnt_r == 5'(CAP_BITS - 1) && comp_r == 2'd2) state_nxt = S_LIM;
      S_LIM:  state_nxt = over ? S_ROOT : S_FIN;
      S_ROOT: if (sq_done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = (comp_r == 2'd2) ? S_FIN : S_MUL;
      S_FIN:  if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---- control outputs
  always_comb begin
    in_tready = 1'b0;
    sq_start  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_LIM:  sq_start  = over;
      S_MUL:  div_start = 1'b1;
      S_FIN:  out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= 12'd500;
      xy_tol_r    <= 12'd200;
      z_tol_r     <= 12'd100;
      home_x_r    <= 16'sd2400;
      home_y_r    <= 16'sd3550;
      hover_r     <= 15'd950;
      side_off_r  <= 16'sd700;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_SPEED:    max_speed_r <= cfg_wdata[11:0];
        REG_XY_TOLERANCE: xy_tol_r    <= cfg_wdata[11:0];
        REG_Z_TOLERANCE:  z_tol_r     <= cfg_wdata[11:0];
        REG_HOME_X:       home_x_r    <= cfg_wdata;
        REG_HOME_Y:       home_y_r    <= cfg_wdata;
        REG_HOVER_HEIGHT: hover_r     <= cfg_wdata[14:0];
        REG_SIDE_OFFSET:  side_off_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- datapath
  assign prod = PROD_W'(a_r[comp_r]) * PROD_W'(max_speed_r);

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          for (int i = 0; i < 3; i++) d_r[i] <= d_in[i];
        end
      end
      S_PREP: begin
        for (int i = 0; i < 3; i++) a_r[i] <= CAP_BITS'(a_w[i] >> kk);
        mcand_r <= SQ_W'(CAP_BITS'(a_w[0] >> kk));
        mpl_r   <= CAP_BITS'(a_w[0] >> kk);
        acc_r   <= '0;
        cnt_r   <= '0;
        comp_r  <= '0;
        arr_r   <= arr_w;
        msq_r   <= 24'(max_speed_r) * 24'(max_speed_r);
      end
      S_SQ: begin
        if (mpl_r[0]) acc_r <= acc_r + mcand_r;
        if (cnt_r == 5'(CAP_BITS - 1)) begin
          cnt_r   <= '0;
          comp_r  <= (comp_r == 2'd2) ? 2'd0 : comp_inc;
          mcand_r <= SQ_W'(a_r[comp_inc]);
          mpl_r   <= a_r[comp_inc];
        end else begin
          cnt_r   <= cnt_r + 5'd1;
          mcand_r <= mcand_r << 1;
          mpl_r   <= mpl_r >> 1;
        end
      end
      S_LIM: begin
        lim_r  <= over;
        comp_r <= '0;
      end
      S_ROOT: if (sq_done) root_r <= sq_root;
      S_DIV: begin
        if (div_done) begin
          q_r[comp_r] <= div_q;
          comp_r      <= comp_inc;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lim_r) vel[i] = d_r[i][DW-1] ? -VEL_W'(q_r[i]) : VEL_W'(q_r[i]);
      else       vel[i] = d_r[i][VEL_W-1:0];
    end
    leg_nxt = leg_r;
    if (arr_r && leg_r != LEG_DONE) begin
      leg_nxt = (32'(leg_r) >= LEG_COUNT) ? LEG_DONE : leg_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leg_r        <= LEG_TAKEOFF;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        leg_r        <= leg_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= OUT_W'({arr_r, leg_nxt, vel[2], vel[1], vel[0]});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  wvs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (acc_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  wvs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod),
    .den   (root_r),
    .done  (div_done),
    .quot  (div_q)
  );

endmodule

`default_nettype wire

@@ rtl/core/wvs_checker.sv @@
// ----------------------------------------------------------------------------
// wvs_checker
// Port-level checks of the waypoint velocity setpoint block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wvs_checker #(
  parameter int LEG_COUNT = 2,
  parameter int IN_W      = 48
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic [IN_W-1:0]            in_tdata,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [wvs_pkg::OUT_W-1:0]  out_tdata
);
  import wvs_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a transaction is in progress");

  a_leg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ARR_BIT-1:LEG_LSB] <= LEG_W'(LEG_COUNT))
    else $error("leg beyond last leg");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("output appeared in the cycle after an input transaction");

endmodule

bind waypoint_velocity_setpoint wvs_checker #(
  .LEG_COUNT (LEG_COUNT),
  .IN_W      (IN_W)
) u_wvs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
